// ===== sv/bltq_pkg.sv =====
// Shared types, field layout and codes for the binary lifting tree query engine.
package bltq_pkg;

   localparam int NODE_W  = 10;
   localparam int DEPTH_W = 10;
   localparam int STEP_W  = 10;
   localparam int SUM_W   = 42;
   localparam int LEN_W   = 11;
   localparam int COUNT_W = 11;
   localparam int LVL_W   = 5;
   localparam int VAL_W   = 32;

   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 72;

   localparam int A_LSB   = 0;
   localparam int B_LSB   = 10;
   localparam int P_LSB   = 20;
   localparam int HP_BIT  = 30;
   localparam int D_LSB   = 31;
   localparam int V_LSB   = 41;
   localparam int S_LSB   = 73;
   localparam int INC_BIT = 83;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

   typedef enum logic [2:0] {
      OP_LOAD    = 3'd0,
      OP_BUILD   = 3'd1,
      OP_LCA     = 3'd2,
      OP_CLIMB   = 3'd3,
      OP_DESCEND = 3'd4,
      OP_PSUM    = 3'd5,
      OP_DIST    = 3'd6,
      OP_NOP     = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_BUILT = 2'd1,
      ST_BUILT     = 2'd2,
      ST_SHALLOW   = 2'd3
   } status_type;

   typedef struct packed {
      op_type             op;
      logic [NODE_W-1:0]  a;
      logic [NODE_W-1:0]  b;
      logic [NODE_W-1:0]  parent;
      logic               has_parent;
      logic               load_ok;
      logic [DEPTH_W-1:0] depth;
      logic [SUM_W-1:0]   value;
      logic [STEP_W-1:0]  steps;
      logic               inclusive;
      logic [COUNT_W-1:0] n;
      logic [LVL_W-1:0]   lv;
   } cmd_type;

   typedef struct packed {
      status_type         status;
      logic [LEN_W-1:0]   path_length;
      logic [SUM_W-1:0]   path_sum;
      logic               node_found;
      logic [NODE_W-1:0]  result_node;
   } rsp_type;

endpackage

// ===== sv/bltq_front.sv =====
// Front end: node count register, item decode, clamping and level count.
module bltq_front
   import bltq_pkg::*;
#(
   parameter int NODES      = 1024,
   parameter int LEVELS     = 10,
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [COUNT_W-1:0]    csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [2:0]            req_tuser,
   input  logic                  queue_full,
   output logic                  push,
   output cmd_type               cmd
);

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;

   always_comb begin
      count_in = csr_we ? csr_wdata : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      int nv;
      int h;
      logic [NODE_W-1:0] na;
      logic [NODE_W-1:0] nb;
      logic [NODE_W-1:0] np;
      nv = int'(count_ff);
      if (nv < 1) nv = 1;
      if (nv > NODES) nv = NODES;
      cmd.lv = LVL_W'(LEVELS);
      for (h = LEVELS; h >= 1; h--) begin
         if ((64'd1 << h) >= 64'(nv)) cmd.lv = LVL_W'(h);
      end
      na = req_tdata[A_LSB +: NODE_W];
      nb = req_tdata[B_LSB +: NODE_W];
      np = req_tdata[P_LSB +: NODE_W];
      cmd.n = COUNT_W'(nv);
      cmd.op = op_type'(req_tuser);
      cmd.a = (int'(na) < nv) ? na : NODE_W'(nv - 1);
      cmd.b = (int'(nb) < nv) ? nb : NODE_W'(nv - 1);
      cmd.parent = (int'(np) >= NODES) ? NODE_W'(NODES - 1) : np;
      cmd.has_parent = req_tdata[HP_BIT];
      cmd.load_ok = int'(na) < NODES;
      if (cmd.op == OP_LOAD) begin
         cmd.a = na;
      end
      cmd.depth = req_tdata[D_LSB +: DEPTH_W];
      cmd.value = SUM_W'($signed(req_tdata[V_LSB +: VALUE_BITS]));
      cmd.steps = req_tdata[S_LSB +: STEP_W];
      cmd.inclusive = req_tdata[INC_BIT];
   end

   assign req_tready = !queue_full;
   assign push = req_tvalid && !queue_full;

endmodule

// ===== sv/bltq_queue.sv =====
// Two-entry command queue between the front end and the lifting engine.
module bltq_queue
   import bltq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    cmd_valid,
   output cmd_type cmd
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   assign full = count_ff == 2'd2;
   assign cmd_valid = count_ff != 2'd0;
   assign cmd = slot_ff[rd_ptr_ff];

endmodule

// ===== sv/bltq_engine.sv =====
// Back end: lifting tables, build sweep, query sequencer and result register.
module bltq_engine
   import bltq_pkg::*;
#(
   parameter int NODES  = 1024,
   parameter int LEVELS = 10
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   localparam int IDX_W   = $clog2(NODES);
   localparam int PTR_W   = $clog2(NODES + 1);
   localparam int ENTRIES = LEVELS * NODES;
   localparam int AW      = $clog2(ENTRIES);
   localparam logic [PTR_W-1:0] NONE_MARK = PTR_W'(NODES);

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_B_ISSUE, S_B_PAR, S_B_WR, S_DEP_A, S_DEP_CHK,
      S_C_LOOP, S_C_WAIT, S_L1_LOOP, S_L1_P, S_L1_D, S_L1_CHK, S_L2_LOOP,
      S_L2_A, S_L2_B, S_L3_W, S_FIN_LCA, S_DIST_W, S_P_DB, S_P_LOOP, S_P_P,
      S_P_D, S_P_INC_W, S_DONE
   } state_type;

   logic [PTR_W-1:0]   ptab_mem [ENTRIES];
   logic [SUM_W-1:0]   stab_mem [ENTRIES];
   logic [DEPTH_W-1:0] dep_mem  [NODES];
   logic [PTR_W-1:0]   ptab_rd_ff;
   logic [SUM_W-1:0]   stab_rd_ff;
   logic [DEPTH_W-1:0] dep_rd_ff;

   logic [AW-1:0]      tab_ra;
   logic [IDX_W-1:0]   dep_ra;
   logic               tab_we;
   logic [AW-1:0]      tab_wa;
   logic [PTR_W-1:0]   ptab_wd;
   logic [SUM_W-1:0]   stab_wd;
   logic               dep_we;
   logic [IDX_W-1:0]   dep_wa;
   logic [DEPTH_W-1:0] dep_wd;

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic               built_ff, built_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic [IDX_W-1:0]   x_ff, x_in;
   logic [IDX_W-1:0]   y_ff, y_in;
   logic [IDX_W-1:0]   na_ff, na_in;
   logic [LVL_W-1:0]   k_ff, k_in;
   logic [COUNT_W-1:0] i_ff, i_in;
   logic [STEP_W-1:0]  steps_ff, steps_in;
   logic [DEPTH_W-1:0] da_ff, da_in;
   logic [DEPTH_W-1:0] db_ff, db_in;
   logic [LEN_W-1:0]   dsum_ff, dsum_in;
   logic [SUM_W-1:0]   sacc_ff, sacc_in;
   logic [SUM_W-1:0]   psum_ff, psum_in;
   logic [IDX_W-1:0]   res_ff, res_in;
   logic               found_ff, found_in;
   status_type         status_ff, status_in;
   logic [LEN_W-1:0]   plen_ff, plen_in;

   function automatic logic [AW-1:0] tab_addr(input logic [LVL_W-1:0] lvl,
                                              input logic [IDX_W-1:0] idx);
      return AW'(lvl) * AW'(NODES) + AW'(idx);
   endfunction

   always_ff @(posedge clock) begin
      if (tab_we) begin
         ptab_mem[tab_wa] <= ptab_wd;
         stab_mem[tab_wa] <= stab_wd;
      end
      ptab_rd_ff <= ptab_mem[tab_ra];
      stab_rd_ff <= stab_mem[tab_ra];
   end

   always_ff @(posedge clock) begin
      if (dep_we) dep_mem[dep_wa] <= dep_wd;
      dep_rd_ff <= dep_mem[dep_ra];
   end

   always_comb begin
      logic [LVL_W-1:0]  ki;
      logic [16:0]       bitval;
      logic              p_none;
      logic [IDX_W-1:0]  p_idx;
      logic [11:0]       span_len;
      logic              nb_none;
      ki = k_ff - LVL_W'(1);
      bitval = 17'd1 << ki;
      p_none = ptab_rd_ff >= NONE_MARK;
      p_idx = IDX_W'(ptab_rd_ff);
      span_len = 12'(dsum_ff) - {1'b0, dep_rd_ff, 1'b0};
      nb_none = 1'b0;

      state_in = state_ff;
      cmd_in = cmd_ff;
      built_in = built_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      x_in = x_ff;
      y_in = y_ff;
      na_in = na_ff;
      k_in = k_ff;
      i_in = i_ff;
      steps_in = steps_ff;
      da_in = da_ff;
      db_in = db_ff;
      dsum_in = dsum_ff;
      sacc_in = sacc_ff;
      psum_in = psum_ff;
      res_in = res_ff;
      found_in = found_ff;
      status_in = status_ff;
      plen_in = plen_ff;
      pop = 1'b0;
      tab_ra = tab_addr(ki, x_ff);
      dep_ra = x_ff;
      tab_we = 1'b0;
      tab_wa = tab_addr(k_ff, IDX_W'(i_ff));
      ptab_wd = ptab_rd_ff;
      stab_wd = stab_rd_ff + sacc_ff;
      dep_we = 1'b0;
      dep_wa = IDX_W'(cmd_ff.a);
      dep_wd = cmd_ff.depth;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               pop = 1'b1;
               cmd_in = cmd;
               x_in = IDX_W'(cmd.a);
               y_in = IDX_W'(cmd.b);
               k_in = cmd.lv;
               steps_in = cmd.steps;
               res_in = '0;
               found_in = 1'b0;
               psum_in = '0;
               plen_in = '0;
               status_in = ST_OK;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            dep_ra = x_ff;
            state_in = S_DONE;
            case (cmd_ff.op)
               OP_LOAD: begin
                  if (built_ff) begin
                     status_in = ST_BUILT;
                  end else if (cmd_ff.load_ok) begin
                     tab_we = 1'b1;
                     tab_wa = tab_addr('0, IDX_W'(cmd_ff.a));
                     ptab_wd = cmd_ff.has_parent ? PTR_W'(cmd_ff.parent) : NONE_MARK;
                     stab_wd = cmd_ff.value;
                     dep_we = 1'b1;
                  end
               end
               OP_BUILD: begin
                  if (built_ff) begin
                     status_in = ST_BUILT;
                  end else begin
                     built_in = 1'b1;
                     k_in = LVL_W'(1);
                     i_in = '0;
                     if (cmd_ff.lv > LVL_W'(1)) state_in = S_B_ISSUE;
                  end
               end
               OP_LCA, OP_CLIMB, OP_DESCEND, OP_PSUM, OP_DIST: begin
                  if (!built_ff) begin
                     status_in = ST_NOT_BUILT;
                  end else if (cmd_ff.op == OP_CLIMB) begin
                     state_in = S_C_LOOP;
                  end else if (cmd_ff.op == OP_PSUM) begin
                     dep_ra = y_ff;
                     state_in = S_P_DB;
                  end else begin
                     state_in = S_DEP_A;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_B_ISSUE: begin
            tab_ra = tab_addr(ki, IDX_W'(i_ff));
            state_in = S_B_PAR;
         end
         S_B_PAR: begin
            if (p_none) begin
               tab_we = 1'b1;
               ptab_wd = NONE_MARK;
               stab_wd = '0;
            end else begin
               sacc_in = stab_rd_ff;
               tab_ra = tab_addr(ki, p_idx);
               state_in = S_B_WR;
            end
         end
         S_B_WR: begin
            tab_we = 1'b1;
         end
         S_DEP_A: begin
            da_in = dep_rd_ff;
            dep_ra = y_ff;
            state_in = S_DEP_CHK;
         end
         S_DEP_CHK: begin
            k_in = cmd_ff.lv;
            if (cmd_ff.op == OP_DESCEND) begin
               db_in = dep_rd_ff;
               if (dep_rd_ff < da_ff) begin
                  status_in = ST_SHALLOW;
                  state_in = S_DONE;
               end else begin
                  x_in = y_ff;
                  state_in = S_C_LOOP;
                  if ((dep_rd_ff - da_ff) > cmd_ff.steps) begin
                     steps_in = STEP_W'(dep_rd_ff - da_ff - DEPTH_W'(cmd_ff.steps));
                  end else begin
                     steps_in = '0;
                  end
               end
            end else begin
               dsum_in = LEN_W'(da_ff) + LEN_W'(dep_rd_ff);
               state_in = S_L1_LOOP;
               if (da_ff < dep_rd_ff) begin
                  x_in = y_ff;
                  y_in = x_ff;
                  db_in = da_ff;
               end else begin
                  db_in = dep_rd_ff;
               end
            end
         end
         S_C_LOOP: begin
            if (k_ff == '0) begin
               found_in = steps_ff == '0;
               res_in = (steps_ff == '0) ? x_ff : '0;
               state_in = S_DONE;
            end else if (17'(steps_ff) >= bitval) begin
               state_in = S_C_WAIT;
            end else begin
               k_in = ki;
            end
         end
         S_C_WAIT: begin
            if (p_none) begin
               found_in = 1'b0;
               res_in = '0;
               state_in = S_DONE;
            end else begin
               x_in = p_idx;
               steps_in = steps_ff - STEP_W'(bitval);
               k_in = ki;
               state_in = S_C_LOOP;
            end
         end
         S_L1_LOOP: begin
            state_in = (k_ff == '0) ? S_L1_CHK : S_L1_P;
         end
         S_L1_P: begin
            if (p_none) begin
               k_in = ki;
               state_in = S_L1_LOOP;
            end else begin
               na_in = p_idx;
               dep_ra = p_idx;
               state_in = S_L1_D;
            end
         end
         S_L1_D: begin
            if (!(dep_rd_ff < db_ff)) x_in = na_ff;
            k_in = ki;
            state_in = S_L1_LOOP;
         end
         S_L1_CHK: begin
            if (x_ff == y_ff) begin
               found_in = 1'b1;
               res_in = x_ff;
               state_in = S_FIN_LCA;
            end else begin
               k_in = cmd_ff.lv;
               state_in = S_L2_LOOP;
            end
         end
         S_L2_LOOP: begin
            if (k_ff == '0) begin
               tab_ra = tab_addr('0, x_ff);
               state_in = S_L3_W;
            end else begin
               state_in = S_L2_A;
            end
         end
         S_L2_A: begin
            sacc_in = SUM_W'({p_none, p_idx});
            tab_ra = tab_addr(ki, y_ff);
            state_in = S_L2_B;
         end
         S_L2_B: begin
            nb_none = sacc_ff[IDX_W];
            if (!(IDX_W'(sacc_ff) == p_idx || nb_none || p_none)) begin
               x_in = IDX_W'(sacc_ff);
               y_in = p_idx;
            end
            k_in = ki;
            state_in = S_L2_LOOP;
         end
         S_L3_W: begin
            found_in = !p_none;
            res_in = p_none ? '0 : p_idx;
            state_in = S_FIN_LCA;
         end
         S_FIN_LCA: begin
            dep_ra = res_ff;
            state_in = S_DONE;
            if (cmd_ff.op == OP_DIST) begin
               if (found_ff) begin
                  state_in = S_DIST_W;
               end else begin
                  plen_in = dsum_ff;
               end
            end
         end
         S_DIST_W: begin
            plen_in = span_len[11] ? '0 : span_len[LEN_W-1:0];
            state_in = S_DONE;
         end
         S_P_DB: begin
            db_in = dep_rd_ff;
            state_in = S_P_LOOP;
         end
         S_P_LOOP: begin
            if (k_ff == '0) begin
               tab_ra = tab_addr('0, y_ff);
               state_in = cmd_ff.inclusive ? S_P_INC_W : S_DONE;
            end else begin
               state_in = S_P_P;
            end
         end
         S_P_P: begin
            if (p_none) begin
               k_in = ki;
               state_in = S_P_LOOP;
            end else begin
               na_in = p_idx;
               sacc_in = stab_rd_ff;
               dep_ra = p_idx;
               state_in = S_P_D;
            end
         end
         S_P_D: begin
            if (!(dep_rd_ff < db_ff)) begin
               psum_in = psum_ff + sacc_ff;
               x_in = na_ff;
            end
            k_in = ki;
            state_in = S_P_LOOP;
         end
         S_P_INC_W: begin
            psum_in = psum_ff + stab_rd_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = status_ff;
               rsp_in.path_length = plen_ff;
               rsp_in.path_sum = psum_ff;
               rsp_in.node_found = found_ff;
               rsp_in.result_node = NODE_W'(res_ff);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if ((state_ff == S_B_PAR && p_none) || state_ff == S_B_WR) begin
         if (i_ff + COUNT_W'(1) < cmd_ff.n) begin
            i_in = i_ff + COUNT_W'(1);
            state_in = S_B_ISSUE;
         end else if (k_ff + LVL_W'(1) < cmd_ff.lv) begin
            k_in = k_ff + LVL_W'(1);
            i_in = '0;
            state_in = S_B_ISSUE;
         end else begin
            state_in = S_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
      x_ff <= x_in;
      y_ff <= y_in;
      na_ff <= na_in;
      k_ff <= k_in;
      i_ff <= i_in;
      steps_ff <= steps_in;
      da_ff <= da_in;
      db_ff <= db_in;
      dsum_ff <= dsum_in;
      sacc_ff <= sacc_in;
      psum_ff <= psum_in;
      res_ff <= res_in;
      found_ff <= found_in;
      status_ff <= status_in;
      plen_ff <= plen_in;
      if (reset) begin
         state_ff <= S_IDLE;
         built_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         built_ff <= built_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

endmodule

// ===== sv/binary_lifting_tree_query.sv =====
// Top level of the binary lifting tree query engine with its assertions.
// A build sweeps each of the n nodes at every level from 1 to L-1.
// Items are carried out one at a time by the engine, which has a single table read port.
// A two-item queue lets new items be taken while the engine works or a result waits.
// Reset empties the queue, clears the built flag and sets the node count to 1024.
module binary_lifting_tree_query
   import bltq_pkg::*;
#(
   parameter int NODES      = 1024,
   parameter int LEVELS     = 10,
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [COUNT_W-1:0]    csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // node_a, node_b, parent_node, has_parent, node_depth, node_value, step_count,
   // inclusive, zero padding.
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // op.
   input  logic [2:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // result_node, node_found, path_sum, path_length, status, zero padding.
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic    queue_full;
   logic    push;
   cmd_type push_cmd;
   logic    pop;
   logic    cmd_valid;
   cmd_type cmd;
   rsp_type rsp;

   bltq_front #(
      .NODES      (NODES),
      .LEVELS     (LEVELS),
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   bltq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   bltq_engine #(
      .NODES  (NODES),
      .LEVELS (LEVELS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .pop       (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {(RSP_DATA_W - $bits(rsp_type))'(0), rsp};

`ifndef NO_ASSERTIONS
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp.node_found |-> rsp.result_node == '0)
      else $error("result node set without a found node");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.status != ST_OK |-> rsp.path_sum == '0 && rsp.path_length == '0)
      else $error("error status carries a path result");

   a_shallow_none: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.status == ST_SHALLOW |-> !rsp.node_found)
      else $error("shallow target reported a node");
`endif

endmodule
